FILE: rtl/core/lis_pkg.sv
// Shared types and constants for the longest-increasing-subsequence block.
// Holds the microcode word layout, the program ROM and field widths.
// No dependencies.
`timescale 1ns / 1ps

package lis_pkg;

  localparam int VALUE_W   = 32;
  localparam int LEN_OUT_W = 11;
  localparam int STEP_W    = 3;

  typedef logic [STEP_W-1:0] step_t;

  // Program step addresses
  localparam step_t ST_IDLE   = 3'd0;
  localparam step_t ST_CMP    = 3'd1;
  localparam step_t ST_SEARCH = 3'd2;
  localparam step_t ST_WRITE  = 3'd3;
  localparam step_t ST_EXT    = 3'd4;
  localparam step_t ST_OUT    = 3'd5;

  // Datapath operation selected by the control word
  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_ACCEPT  = 3'd1,
    OP_CMPLAST = 3'd2,
    OP_SEARCH  = 3'd3,
    OP_WRITE   = 3'd4,
    OP_EXT     = 3'd5,
    OP_OUT     = 3'd6
  } op_t;

  // Branch condition selected by the control word
  typedef enum logic [2:0] {
    C_ALWAYS  = 3'd0,
    C_INVALID = 3'd1,
    C_EXT     = 3'd2,
    C_SDONE   = 3'd3,
    C_OUTFREE = 3'd4
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt_t;   // next step when the condition holds
    step_t tgt_f;   // next step otherwise
  } uword_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic ext;
    logic sdone;
    logic out_free;
  } stat_t;

  // Program ROM
  function automatic uword_t ucode_rom(input step_t step);
    uword_t w;
    unique case (step)
      ST_IDLE:   w = '{OP_ACCEPT,  C_INVALID, ST_CMP,   ST_IDLE};
      ST_CMP:    w = '{OP_CMPLAST, C_EXT,     ST_EXT,   ST_SEARCH};
      ST_SEARCH: w = '{OP_SEARCH,  C_SDONE,   ST_WRITE, ST_SEARCH};
      ST_WRITE:  w = '{OP_WRITE,   C_ALWAYS,  ST_OUT,   ST_OUT};
      ST_EXT:    w = '{OP_EXT,     C_ALWAYS,  ST_OUT,   ST_OUT};
      ST_OUT:    w = '{OP_OUT,     C_OUTFREE, ST_IDLE,  ST_OUT};
      default:   w = '{OP_NOP,     C_ALWAYS,  ST_IDLE,  ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/lis_ifs.sv
// Valid/ready channel interfaces for the input items and the results.
// Depends on lis_pkg for field widths.
`timescale 1ns / 1ps

interface lis_in_if import lis_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      first;

  modport source (output valid, value, first, input ready);
  modport sink   (input valid, value, first, output ready);
endinterface

interface lis_out_if import lis_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [LEN_OUT_W-1:0] length;
  logic                 overflow;

  modport source (output valid, length, overflow, input ready);
  modport sink   (input valid, length, overflow, output ready);
endinterface

FILE: rtl/core/lis_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/lis_ctrl.sv
// Microcode sequencer: step counter, program ROM lookup and branch logic.
// Depends on lis_pkg for the control word, ROM and status struct.
`timescale 1ns / 1ps

module lis_ctrl import lis_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output op_t   op
);

  step_t  step_r, step_nxt;
  uword_t uw;
  logic   cond_hit;

  assign uw = ucode_rom(step_r);
  assign op = uw.op;

  // Branch condition decode
  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:  cond_hit = 1'b1;
      C_INVALID: cond_hit = stat.in_valid;
      C_EXT:     cond_hit = stat.ext;
      C_SDONE:   cond_hit = stat.sdone;
      C_OUTFREE: cond_hit = stat.out_free;
      default:   cond_hit = 1'b1;
    endcase
  end

  assign step_nxt = cond_hit ? uw.tgt_t : uw.tgt_f;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

FILE: rtl/core/lis_length_tails_stream.sv
// Streaming longest strictly increasing subsequence length (smallest tails).
// Each item is taken in and compared with the last tail; it then extends the
// table, or a binary search finds the tail that it replaces, one probe of the
// single-port tail RAM per cycle. The length is then offered as a result, held
// while the result stalls. One item at a time: none is taken until then.
// Reset clears the length, overflow flag and output slot; the tail RAM is not cleared.
`timescale 1ns / 1ps

module lis_length_tails_stream import lis_pkg::*; #(
  parameter int MAX_LEN = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  lis_in_if.sink           in_ch,
  lis_out_if.source        out_ch
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);

  op_t   op;
  stat_t stat;

  logic signed [VALUE_W-1:0] val_r;
  logic [LW-1:0]             len_r;
  logic                      ovf_r;
  logic [AW-1:0]             lo_r, hi_r, mid_r;
  logic                      out_valid_r;
  logic [LEN_OUT_W-1:0]      out_len_r;
  logic                      out_ovf_r;

  logic                      in_xfer;
  logic [LW-1:0]             eff_len, eff_m1, len_m1, len_half;
  logic                      len_full;
  logic [VALUE_W-1:0]        rdata;
  logic                      ram_we;
  logic [AW-1:0]             ram_addr;
  logic                      probe_lt;
  logic [AW-1:0]             lo_nxt, hi_nxt, mid_nxt;
  logic [AW:0]               mid_sum;
  logic                      out_free;
  logic [LW+LEN_OUT_W-1:0]   len_ext;

  // Sequencer
  lis_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  // Tail table
  lis_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_LEN)
  ) u_tails (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (val_r),
    .rdata (rdata)
  );

  // Handshake and length helpers
  assign in_ch.ready = (op == OP_ACCEPT);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign eff_len     = in_ch.first ? '0 : len_r;
  assign eff_m1      = eff_len - 1'b1;
  assign len_m1      = len_r - 1'b1;
  assign len_half    = len_m1 >> 1;
  assign len_full    = (len_r >= LW'(MAX_LEN));

  // One binary search probe: data for mid_r is on rdata
  assign probe_lt = $signed(rdata) < val_r;
  assign lo_nxt   = probe_lt ? AW'(mid_r + 1'b1) : lo_r;
  assign hi_nxt   = probe_lt ? hi_r : mid_r;
  assign mid_sum  = {1'b0, lo_nxt} + {1'b0, hi_nxt};
  assign mid_nxt  = mid_sum[AW:1];

  assign out_free = !out_valid_r || out_ch.ready;

  // Status back to the sequencer
  assign stat.in_valid = in_ch.valid;
  assign stat.ext      = (len_r == '0) || ($signed(rdata) < val_r);
  assign stat.sdone    = (lo_r == hi_r) || (lo_nxt == hi_nxt);
  assign stat.out_free = out_free;

  // RAM port steering
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = lo_r;
    unique case (op) inside
      OP_ACCEPT:  ram_addr = eff_m1[AW-1:0];
      OP_CMPLAST: ram_addr = len_half[AW-1:0];
      OP_SEARCH:  ram_addr = mid_nxt;
      OP_WRITE: begin
        ram_we   = 1'b1;
        ram_addr = lo_r;
      end
      OP_EXT: begin
        ram_we   = !len_full;
        ram_addr = len_r[AW-1:0];
      end
      OP_OUT, OP_NOP: ram_addr = lo_r;
      default:        ram_addr = lo_r;
    endcase
  end

  // Table state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        len_r <= eff_len;
        if (in_ch.first) begin
          ovf_r <= 1'b0;
        end
      end else if (op == OP_EXT) begin
        if (len_full) begin
          ovf_r <= 1'b1;
        end else begin
          len_r <= len_r + 1'b1;
        end
      end
    end
  end

  // Search registers and latched value
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      val_r <= in_ch.value;
    end
    if (op == OP_CMPLAST) begin
      lo_r  <= '0;
      hi_r  <= len_m1[AW-1:0];
      mid_r <= len_half[AW-1:0];
    end else if (op == OP_SEARCH && lo_r != hi_r) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      mid_r <= mid_nxt;
    end
  end

  // Result register
  assign len_ext = {{LEN_OUT_W{1'b0}}, len_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == OP_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_OUT && out_free) begin
      out_len_r <= len_ext[LEN_OUT_W-1:0];
      out_ovf_r <= ovf_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.length   = out_len_r;
  assign out_ch.overflow = out_ovf_r;

endmodule
